>>> hw/rtl/pcbm_pkg.sv
// Package: shared types and constants for the PMU counter bank manager.
`default_nettype none
package pcbm_pkg;
    localparam int MODE_W = 3;
    localparam int BASE_W = 6;
    localparam int FLAGS_W = 16;
    localparam int EV_W = 20;
    localparam int ERR_W = 2;
    localparam int CSR_W = 12;
    localparam int HWW_W = 7;

    localparam logic [MODE_W-1:0] MODE_COUNT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INFO = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONFIG = 3'd2;
    localparam logic [MODE_W-1:0] MODE_START = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOP = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FW_READ = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FW_READ_HI = 3'd6;
    localparam logic [MODE_W-1:0] MODE_FW_EVENT = 3'd7;

    localparam logic [ERR_W-1:0] ERR_OK = 2'd0;
    localparam logic [ERR_W-1:0] ERR_INVALID = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNSUPPORTED = 2'd2;

    localparam logic [0:0] REG_CSR_BASE = 1'd0;
    localparam logic [0:0] REG_HW_WIDTH = 1'd1;

    localparam logic [3:0] FW_EVENT_TYPE = 4'd15;
    localparam logic [CSR_W-1:0] CSR_BASE_RESET = 12'd3075;
    localparam logic [HWW_W-1:0] HW_WIDTH_RESET = 7'd64;

    localparam logic [FLAGS_W-1:0] CFG_RESERVED = 16'hFF00;
    localparam logic [FLAGS_W-1:0] RUN_RESERVED = 16'hFFFC;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BASE_W-1:0]  counter_base;
        logic [63:0]        counter_mask;
        logic [FLAGS_W-1:0] flags;
        logic [EV_W-1:0]    event_code;
        logic [63:0]        init_value;
    } req_t;

    typedef struct packed {
        logic [ERR_W-1:0] error;
        logic [63:0]      value;
    } rsp_t;

    typedef struct packed {
        logic [0:0]       index;
        logic [CSR_W-1:0] data;
    } cfg_t;
endpackage
`default_nettype wire

>>> hw/rtl/pcbm_if.sv
// Interfaces: valid/ready channels for requests, responses and register writes.
`default_nettype none
interface pcbm_req_if import pcbm_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pcbm_rsp_if import pcbm_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pcbm_cfg_if import pcbm_pkg::*; ();
    logic valid;
    logic ready;
    cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pcbm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module pcbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/pmu_counter_bank_manager_unit.sv
// PMU counter bank manager: one transaction per SBI PMU call, memory-held counter state.
//
// Counter values, event selectors and running bits live in a RAM with registered read
// data, one word per counter, with a valid bit per counter giving the all-zero reset.
// Count, info and argument errors pass from the read state through the done and
// output states to the result; a firmware read passes address, read wait, capture,
// then the done and output states. Config match, start, stop and firmware event walk
// the mask bits (or the counters) one per cycle and pass through a modify state on
// each counter they touch, since read data is registered; the result follows through
// the done and output states after the last bit. The next transaction is taken once
// the result has been accepted.
`default_nettype none
module pmu_counter_bank_manager_unit
    import pcbm_pkg::*;
#(
    parameter int HW_COUNTERS = 29,
    parameter int FW_COUNTERS = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    pcbm_req_if.sink   req,
    pcbm_rsp_if.source rsp,
    pcbm_cfg_if.sink   cfg
);
    localparam int NUM = HW_COUNTERS + FW_COUNTERS;
    localparam int IDX_W = $clog2(NUM);
    localparam int SCAN_W = 7;
    localparam int WORD_W = 64 + 1 + EV_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_MOD   = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [CSR_W-1:0] csr_base_reg;
    logic [HWW_W-1:0] hw_width_reg;
    logic [NUM-1:0]   written_reg, written_next;
    logic [SCAN_W-1:0] bit_reg, bit_next;
    logic [ERR_W-1:0] err_reg, err_next;
    logic [63:0]      val_reg, val_next;
    logic             out_valid_reg;
    rsp_t             out_reg;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [WORD_W-1:0] wdata, rdata, word;

    pcbm_ram #(.WIDTH(WORD_W), .DEPTH(NUM)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_reg;

    // current scan index and request decode
    logic [SCAN_W:0] idx_full;
    logic            in_bank, is_hw_idx, sel_bit, ev_hw, is_cfg, is_run, is_ev;
    logic [IDX_W-1:0] idx;
    logic [63:0]     cur_val;
    logic            cur_run;
    logic [EV_W-1:0] cur_ev;
    logic [6:0]      width_c;

    assign is_cfg = req_reg.mode == MODE_CONFIG;
    assign is_run = req_reg.mode == MODE_START || req_reg.mode == MODE_STOP;
    assign is_ev = req_reg.mode == MODE_FW_EVENT;
    assign idx_full = is_ev ? {1'b0, bit_reg} :
        ({2'b0, req_reg.counter_base} + {1'b0, bit_reg});
    assign in_bank = idx_full < (SCAN_W+1)'(NUM);
    assign idx = idx_full[IDX_W-1:0];
    assign is_hw_idx = idx_full < (SCAN_W+1)'(HW_COUNTERS);
    assign sel_bit = is_ev ? (bit_reg >= SCAN_W'(HW_COUNTERS)) :
        req_reg.counter_mask[bit_reg[5:0]];
    assign ev_hw = req_reg.event_code[19:16] != FW_EVENT_TYPE;
    assign word = written_reg[idx] ? rdata : '0;
    assign cur_val = word[WORD_W-1:EV_W+1];
    assign cur_run = word[EV_W];
    assign cur_ev = word[EV_W-1:0];
    assign width_c = (hw_width_reg == '0) ? 7'd1 :
        (hw_width_reg > 7'd64) ? 7'd64 : hw_width_reg;

    logic [SCAN_W-1:0] scan_end;
    assign scan_end = is_ev ? SCAN_W'(NUM) : SCAN_W'(64);

    always_comb
    begin
        state_next = state_reg;
        written_next = written_reg;
        bit_next = bit_reg;
        err_next = err_reg;
        val_next = val_reg;
        we = 1'b0;
        waddr = idx;
        wdata = word;
        raddr = idx;
        unique case (state_reg)
            ST_IDLE:
            begin
                bit_next = '0;
                err_next = ERR_OK;
                val_next = '0;
                if (req.valid && req.ready)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
                if (req_reg.mode == MODE_COUNT)
                begin
                    val_next = 64'(NUM);
                end
                else if (req_reg.mode == MODE_INFO)
                begin
                    if (req_reg.counter_base >= BASE_W'(NUM))
                        err_next = ERR_INVALID;
                    else if (req_reg.counter_base < BASE_W'(HW_COUNTERS))
                        val_next = {46'd0, 6'(width_c - 7'd1),
                            csr_base_reg + {6'd0, req_reg.counter_base}};
                    else
                        val_next = {1'b1, 45'd0, 6'd63, 12'd0};
                end
                else if (req_reg.mode == MODE_FW_READ || req_reg.mode == MODE_FW_READ_HI)
                begin
                    if (req_reg.counter_base < BASE_W'(HW_COUNTERS)
                        || req_reg.counter_base >= BASE_W'(NUM))
                        err_next = ERR_INVALID;
                    else if (req_reg.mode == MODE_FW_READ)
                    begin
                        raddr = req_reg.counter_base[IDX_W-1:0];
                        state_next = ST_WAIT;
                    end
                end
                else if (is_cfg && ((req_reg.flags & CFG_RESERVED) != '0
                    || req_reg.counter_base >= BASE_W'(NUM)))
                    err_next = ERR_INVALID;
                else if (is_run && (req_reg.flags & RUN_RESERVED) != '0)
                    err_next = ERR_INVALID;
                else if (is_ev && req_reg.event_code == '0)
                    state_next = ST_DONE;
                else if (bit_reg == scan_end)
                begin
                    if (is_cfg) err_next = ERR_UNSUPPORTED;
                end
                else if (!sel_bit)
                begin
                    bit_next = bit_reg + 1'b1;
                    state_next = ST_READ;
                end
                else if (!in_bank)
                begin
                    err_next = ERR_INVALID;
                    if (is_run)
                    begin
                        bit_next = bit_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
                else if (is_cfg && is_hw_idx != ev_hw)
                    err_next = ERR_INVALID;
                else
                begin
                    state_next = ST_MOD;
                end
            end
            ST_WAIT:
            begin
                raddr = req_reg.counter_base[IDX_W-1:0];
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                state_next = ST_READ;
                bit_next = bit_reg + 1'b1;
                if (req_reg.mode == MODE_FW_READ)
                begin
                    val_next = (written_reg[req_reg.counter_base[IDX_W-1:0]]) ?
                        rdata[WORD_W-1:EV_W+1] : '0;
                    state_next = ST_DONE;
                end
                else if (is_cfg)
                begin
                    if (req_reg.flags[0] || (!cur_run
                        && !(ev_hw && cur_ev != '0)))
                    begin
                        state_next = ST_DONE;
                        if (ev_hw && req_reg.event_code[19:16] > 4'd1)
                            err_next = ERR_UNSUPPORTED;
                        else
                        begin
                            val_next = 64'(idx);
                            we = 1'b1;
                            written_next[idx] = 1'b1;
                            wdata = {req_reg.flags[1] ? 64'd0 : cur_val,
                                req_reg.flags[2] | cur_run, req_reg.event_code};
                        end
                    end
                end
                else if (req_reg.mode == MODE_START)
                begin
                    we = 1'b1;
                    written_next[idx] = 1'b1;
                    wdata = {req_reg.flags[0] ? req_reg.init_value : cur_val,
                        1'b1, cur_ev};
                end
                else if (req_reg.mode == MODE_STOP)
                begin
                    we = 1'b1;
                    written_next[idx] = 1'b1;
                    wdata = {cur_val, 1'b0, req_reg.flags[0] ? EV_W'(0) : cur_ev};
                end
                else if (cur_run && cur_ev == req_reg.event_code)
                begin
                    we = 1'b1;
                    written_next[idx] = 1'b1;
                    wdata = {cur_val + 64'd1, cur_run, cur_ev};
                end
            end
            ST_DONE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            written_reg <= '0;
            out_valid_reg <= 1'b0;
            csr_base_reg <= CSR_BASE_RESET;
            hw_width_reg <= HW_WIDTH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            written_reg <= written_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.data.index)
                    REG_CSR_BASE: csr_base_reg <= cfg.data.data;
                    REG_HW_WIDTH: hw_width_reg <= cfg.data.data[HWW_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        err_reg <= err_next;
        val_reg <= val_next;
        if (req.valid && req.ready)
            req_reg <= req.data;
        if (state_reg == ST_OUT)
        begin
            out_reg.error <= err_reg;
            out_reg.value <= (err_reg != ERR_OK) ? 64'd0 : val_reg;
        end
    end

    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.error != ERR_OK |-> rsp.data.value == '0)
        else $error("nonzero value with error");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !req.ready)
        else $error("accept while busy");
    a_hw_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        we && is_ev |-> idx_full >= (SCAN_W+1)'(HW_COUNTERS))
        else $error("event hit hardware counter");
endmodule
`default_nettype wire

>>> tb/pcbm_tb_if.sv
// Testbench interface file: the testbench uses the channel interfaces declared with the RTL.
`default_nettype none
`default_nettype wire

>>> tb/pmu_counter_bank_manager_unit_tb.sv
// Testbench for the PMU counter bank manager: random and directed SBI PMU calls checked against a predictor.
`default_nettype none
module pmu_counter_bank_manager_unit_tb;
    import pcbm_pkg::*;

    localparam int HW_N = 29;
    localparam int FW_N = 16;
    localparam int ALL_N = HW_N + FW_N;
    localparam logic [FLAGS_W-1:0] CFG_SKIP = 16'h1;
    localparam logic [FLAGS_W-1:0] CFG_CLEAR = 16'h2;
    localparam logic [FLAGS_W-1:0] CFG_AUTO = 16'h4;
    localparam logic [FLAGS_W-1:0] RUN_SET = 16'h1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pcbm_req_if req ();
    pcbm_rsp_if rsp ();
    pcbm_cfg_if cfg ();

    pmu_counter_bank_manager_unit #(.HW_COUNTERS(HW_N), .FW_COUNTERS(FW_N)) i_dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [CSR_W-1:0] mdl_csr_base;
    logic [HWW_W-1:0] mdl_hw_width;
    logic [63:0] mdl_value [ALL_N];
    logic [EV_W-1:0] mdl_select [ALL_N];
    logic mdl_running [ALL_N];
    rsp_t expected_rsp [$];
    int errors = 0;
    bit hold_off = 1'b0;
    bit burst_mode = 1'b1;

    initial
    begin
        req.valid = 1'b0;
        req.data = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    function automatic logic [63:0] info_word(input int idx);
        int w;
        logic [CSR_W-1:0] csr;
        if (idx >= HW_N)
            return (64'd63 << 12) | (64'd1 << 63);
        w = mdl_hw_width;
        if (w == 0) w = 1;
        if (w > 64) w = 64;
        csr = mdl_csr_base + idx[CSR_W-1:0];
        return {52'd0, csr} | (64'(w - 1) << 12);
    endfunction

    function automatic rsp_t predict_call(input req_t r);
        rsp_t o;
        int idx;
        int sel;
        bit hwk;
        bit found;
        bit bad;
        logic [3:0] typ;
        o = '0;
        case (r.mode)
            MODE_COUNT: o.value = 64'(ALL_N);
            MODE_INFO:
                if (r.counter_base < ALL_N) o.value = info_word(int'(r.counter_base));
                else o.error = ERR_INVALID;
            MODE_CONFIG:
            begin
                typ = r.event_code[19:16];
                hwk = (typ != FW_EVENT_TYPE);
                found = 1'b0;
                bad = 1'b0;
                sel = 0;
                if ((r.flags & CFG_RESERVED) != 0 || r.counter_base >= ALL_N)
                    bad = 1'b1;
                for (int b = 0; b < 64 && !found && !bad; b++)
                begin
                    if (r.counter_mask[b])
                    begin
                        idx = r.counter_base + b;
                        if (idx >= ALL_N || ((idx < HW_N) != hwk))
                            bad = 1'b1;
                        else if ((r.flags & CFG_SKIP) != 0 || (!mdl_running[idx] &&
                                 !(hwk && mdl_select[idx] != 0)))
                        begin
                            sel = idx;
                            found = 1'b1;
                        end
                    end
                end
                if (bad)
                    o.error = ERR_INVALID;
                else if (!found || (hwk && typ > 1))
                    o.error = ERR_UNSUPPORTED;
                else
                begin
                    mdl_select[sel] = r.event_code;
                    if ((r.flags & CFG_CLEAR) != 0) mdl_value[sel] = '0;
                    if ((r.flags & CFG_AUTO) != 0) mdl_running[sel] = 1'b1;
                    o.value = 64'(sel);
                end
            end
            MODE_START, MODE_STOP:
                if ((r.flags & RUN_RESERVED) != 0)
                    o.error = ERR_INVALID;
                else
                    for (int b = 0; b < 64; b++)
                    begin
                        if (r.counter_mask[b])
                        begin
                            idx = r.counter_base + b;
                            if (idx >= ALL_N)
                                o.error = ERR_INVALID;
                            else if (r.mode == MODE_START)
                            begin
                                if ((r.flags & RUN_SET) != 0) mdl_value[idx] = r.init_value;
                                mdl_running[idx] = 1'b1;
                            end
                            else
                            begin
                                mdl_running[idx] = 1'b0;
                                if ((r.flags & RUN_SET) != 0) mdl_select[idx] = '0;
                            end
                        end
                    end
            MODE_FW_READ, MODE_FW_READ_HI:
                if (r.counter_base < HW_N || r.counter_base >= ALL_N) o.error = ERR_INVALID;
                else if (r.mode == MODE_FW_READ) o.value = mdl_value[r.counter_base];
            default:
                if (r.event_code != 0)
                    for (int i = HW_N; i < ALL_N; i++)
                        if (mdl_running[i] && mdl_select[i] == r.event_code)
                            mdl_value[i] = mdl_value[i] + 64'd1;
        endcase
        if (o.error != ERR_OK) o.value = '0;
        return o;
    endfunction

    task automatic send_call(input req_t r);
        req.valid <= 1'b1;
        req.data <= r;
        expected_rsp.push_back(predict_call(r));
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] index, input logic [CSR_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.data <= '{index: index, data: value};
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        if (index == REG_CSR_BASE) mdl_csr_base = value;
        else mdl_hw_width = value[HWW_W-1:0];
        @(posedge clk);
    endtask

    task automatic drain();
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic req_t make_call(input logic [2:0] m, input int base,
                                       input logic [63:0] mask, input logic [15:0] fl,
                                       input logic [19:0] ev, input logic [63:0] init);
        req_t r;
        r.mode = m;
        r.counter_base = base[5:0];
        r.counter_mask = mask;
        r.flags = fl;
        r.event_code = ev;
        r.init_value = init;
        return r;
    endfunction

    function automatic req_t random_call();
        req_t r;
        int k;
        r.mode = 3'($urandom_range(0, 7));
        r.counter_mask = {$urandom, $urandom};
        r.init_value = {$urandom, $urandom};
        r.flags = 16'($urandom);
        r.event_code = 20'($urandom);
        r.counter_base = 6'($urandom);
        k = $urandom_range(0, 9);
        if (k < 8)
        begin
            r.flags = r.flags & 16'h0007;
            if (r.mode == MODE_START || r.mode == MODE_STOP) r.flags = r.flags & 16'h3;
            r.event_code = (k < 5) ? {4'hF, 12'd0, 4'($urandom_range(1, 3))}
                                   : {4'($urandom_range(0, 2)), 16'($urandom_range(0, 3))};
            if ($urandom_range(0, 1)) r.counter_base = 6'($urandom_range(0, ALL_N - 1));
            else if (r.mode >= MODE_FW_READ)
                r.counter_base = 6'($urandom_range(HW_N, ALL_N - 1));
            case ($urandom_range(0, 2))
                0: r.counter_mask = 64'd1 << $urandom_range(0, 3);
                1: r.counter_mask = {60'd0, 4'($urandom)};
                default: ;
            endcase
            if (r.mode == MODE_CONFIG && r.event_code[19:16] == 4'hF && k < 6)
                r.counter_base = 6'($urandom_range(HW_N, ALL_N - 1));
        end
        return r;
    endfunction

    task automatic test_directed();
        send_call(make_call(MODE_COUNT, 0, '0, '0, '0, '0));
        send_call(make_call(MODE_INFO, 0, '0, '0, '0, '0));
        send_call(make_call(MODE_INFO, HW_N - 1, '0, '0, '0, '0));
        send_call(make_call(MODE_INFO, HW_N, '0, '0, '0, '0));
        send_call(make_call(MODE_INFO, 63, '0, '0, '0, '0));
        send_call(make_call(MODE_CONFIG, HW_N, 64'h3, CFG_CLEAR | CFG_AUTO, 20'hF0001, '0));
        send_call(make_call(MODE_CONFIG, HW_N, 64'h3, CFG_AUTO, 20'hF0001, '0));
        send_call(make_call(MODE_FW_EVENT, 0, '0, '0, 20'hF0001, '0));
        send_call(make_call(MODE_FW_EVENT, 0, '0, '0, 20'h0, '0));
        send_call(make_call(MODE_FW_READ, HW_N, '0, '0, '0, '0));
        send_call(make_call(MODE_FW_READ_HI, HW_N, '0, '0, '0, '0));
        send_call(make_call(MODE_FW_READ, 3, '0, '0, '0, '0));
        send_call(make_call(MODE_START, HW_N, 64'h1, RUN_SET, 20'h0, '1));
        send_call(make_call(MODE_FW_EVENT, 0, '0, '0, 20'hF0001, '0));
        send_call(make_call(MODE_FW_READ, HW_N, '0, '0, '0, '0));
        send_call(make_call(MODE_CONFIG, 0, 64'h1, 16'h00F8, 20'h00005, '0));
        send_call(make_call(MODE_CONFIG, 0, 64'h1, '0, 20'h00006, '0));
        send_call(make_call(MODE_CONFIG, 0, 64'h1, CFG_SKIP, 20'h10007, '0));
        send_call(make_call(MODE_CONFIG, 0, 64'h1, '0, 20'h30001, '0));
        send_call(make_call(MODE_CONFIG, 0, '1, '0, 20'h00001, '0));
        send_call(make_call(MODE_CONFIG, ALL_N, 64'h1, '0, 20'h00001, '0));
        send_call(make_call(MODE_CONFIG, 0, 64'h1, CFG_RESERVED, 20'h00001, '0));
        send_call(make_call(MODE_START, 0, '1, RUN_RESERVED, 20'h0, '0));
        send_call(make_call(MODE_STOP, 40, '1, RUN_SET, 20'h0, '0));
        send_call(make_call(MODE_FW_EVENT, 0, '0, '0, 20'hFFFFF, '0));
        drain();
    endtask

    task automatic test_registers(input logic [CSR_W-1:0] base, input logic [CSR_W-1:0] w);
        write_reg(REG_CSR_BASE, base);
        write_reg(REG_HW_WIDTH, w);
        send_call(make_call(MODE_INFO, 0, '0, '0, '0, '0));
        send_call(make_call(MODE_INFO, HW_N - 1, '0, '0, '0, '0));
        drain();
    endtask

    task automatic test_random(input int n);
        int gap;
        for (int i = 0; i < n; i++)
        begin
            if (burst_mode && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 12);
                repeat (gap) @(posedge clk);
            end
            send_call(random_call());
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random(20);
        drain();
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rsp.valid && rsp.ready)
        begin
            if (expected_rsp.size() == 0)
                report("unexpected transaction", rsp.data.value, '0);
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.data.error !== want.error)
                    report("error", 64'(rsp.data.error), 64'(want.error));
                if (rsp.data.value !== want.value)
                    report("value", rsp.data.value, want.value);
            end
        end
    end

    initial
    begin
        int phase;
        int stall_left;
        phase = 0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                stall_left = 400;
            end
            phase++;
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if ((phase / 200) % 2 == 0)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
        end
    end

    initial
    begin
        #40000000;
        $display("pmu_counter_bank_manager_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        mdl_csr_base = CSR_BASE_RESET;
        mdl_hw_width = HW_WIDTH_RESET;
        for (int i = 0; i < ALL_N; i++)
        begin
            mdl_value[i] = '0;
            mdl_select[i] = '0;
            mdl_running[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_registers(12'hFFF, 12'd0);
        test_registers(12'h000, 12'd127);
        test_registers(12'h555, 12'd1);
        test_registers(12'hAAA, 12'd33);
        test_backpressure();
        test_random(700);
        drain();
        test_registers(12'hFF0, 12'd64);
        test_random(700);
        burst_mode = 1'b0;
        test_random(600);
        drain();
        if (errors == 0)
            $display("pmu_counter_bank_manager_unit_tb: done, clean");
        else
            $display("pmu_counter_bank_manager_unit_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
hw/rtl/pcbm_pkg.sv
hw/rtl/pcbm_if.sv
hw/rtl/pcbm_ram.sv
hw/rtl/pmu_counter_bank_manager_unit.sv
tb/pcbm_tb_if.sv
tb/pmu_counter_bank_manager_unit_tb.sv
